### design/lsh_pkg.sv
// Shared constants, register codes and the front-to-back queue entry of the sharpen unit.
`default_nettype none

package lsh_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W      = 8;
  localparam int FRAME_W_W  = 12;
  localparam int FRAME_H_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // One neighborhood, ready for the back end to evaluate.
  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic             border;
    logic             last_row;
    logic             row_end;
  } lsh_entry_t;

endpackage

`default_nettype wire

### design/laplacian_sharpen_3x3_unit.sv
// A result is held in the queue, then in the output register, after its pixel transfer.
// Throughput: one pixel per cycle while the queue is not full, set by the single write port of each
//   line store; last-row pixels yield two results each, so there the output register slows intake.
// Rows 1..H-1 yield the sharpened pixel above, the last row a zero pixel too; the frame end carries tlast.
// Reset (asynchronous, active low) clears counters, queue and output; frame size returns to
//   640 x 480. Line stores are not cleared and hold nothing meaningful until first written.
`default_nettype none

module laplacian_sharpen_3x3_unit #(
  parameter int MAX_WIDTH  = lsh_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lsh_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input transfer
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [lsh_pkg::PIX_W-1:0]       s_tdata_i,   // [7:0] pixel_in
  // sharpened pixel output transfer
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [lsh_pkg::PIX_W-1:0]       m_tdata_o,   // [7:0] pixel_out
  output logic                            m_tlast_o,   // frame_last
  // register writes: index 0 frame_width, index 1 frame_height
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lsh_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [lsh_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lsh_pkg::*;

  lsh_entry_t push_entry, head_entry;
  logic       q_push, q_full, q_valid, q_pop;

  // front: counters, line stores and neighborhood gathering
  lsh_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  // decoupling queue, lets the output side stall without stopping intake at once
  lsh_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (push_entry),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (head_entry),
    .pop_i  (q_pop)
  );

  // back: kernel arithmetic and result emission
  lsh_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (head_entry),
    .q_pop_o   (q_pop),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tlast_o (m_tlast_o)
  );

endmodule

`default_nettype wire

### design/lsh_front.sv
// Front end: pixel intake, line stores, raster counters and neighborhood classification.
`default_nettype none

module lsh_front #(
  parameter int MAX_WIDTH  = lsh_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lsh_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [lsh_pkg::PIX_W-1:0]       s_tdata_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lsh_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [lsh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output lsh_pkg::lsh_entry_t             q_entry_o
);
  import lsh_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WE_W  = COL_W + 1;
  localparam int HE_W  = ROW_W + 1;

  logic [FRAME_W_W-1:0] frame_width_q;
  logic [FRAME_H_W-1:0] frame_height_q;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [PIX_W-1:0]     held_left_q, held_left_d;
  logic [WE_W-1:0]      w_eff;
  logic [HE_W-1:0]      h_eff;
  logic                 acc, row_end, last_row;
  logic [COL_W-1:0]     rd_addr, rd_addr_nx;

  logic [PIX_W-1:0] line_above [MAX_WIDTH];
  logic [PIX_W-1:0] line_two   [MAX_WIDTH];
  logic [PIX_W-1:0] rd_above_q, rd_right_q, rd_two_q;

  assign s_tready_o  = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign acc         = s_tvalid_i && s_tready_o;

  // effective frame size, clamped to 3..MAX
  always_comb begin
    if (frame_width_q < FRAME_W_W'(3)) begin
      w_eff = WE_W'(3);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(frame_width_q);
    end
    if (frame_height_q < FRAME_H_W'(3)) begin
      h_eff = HE_W'(3);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h_eff = HE_W'(MAX_HEIGHT);
    end else begin
      h_eff = HE_W'(frame_height_q);
    end
  end

  assign row_end  = WE_W'(col_q) >= (w_eff - WE_W'(1));
  assign last_row = HE_W'(row_q) >= (h_eff - HE_W'(1));

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    held_left_d = held_left_q;
    if (acc) begin
      held_left_d = rd_above_q;
      if (row_end) begin
        col_d       = '0;
        held_left_d = '0;
        row_d       = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // read ahead for the column that the next pixel will land on
  assign rd_addr    = col_d;
  assign rd_addr_nx = (rd_addr == COL_W'(MAX_WIDTH - 1)) ? '0 : rd_addr + COL_W'(1);

  always_ff @(posedge clk_i) begin
    rd_above_q <= line_above[rd_addr];
    rd_right_q <= line_above[rd_addr_nx];
    rd_two_q   <= line_two[rd_addr];
    if (acc) begin
      line_above[col_q] <= s_tdata_i;
      line_two[col_q]   <= rd_above_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q          <= '0;
      row_q          <= '0;
      held_left_q    <= '0;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      held_left_q <= held_left_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FRAME_W_W-1:0];
          CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // row 0 has no output of its own
  assign q_push_o           = acc && (row_q != '0);
  assign q_entry_o.center   = rd_above_q;
  assign q_entry_o.left     = held_left_q;
  assign q_entry_o.right    = rd_right_q;
  assign q_entry_o.up       = rd_two_q;
  assign q_entry_o.down     = s_tdata_i;
  assign q_entry_o.border   = (row_q == ROW_W'(1)) || (col_q == '0) || row_end;
  assign q_entry_o.last_row = last_row;
  assign q_entry_o.row_end  = row_end;

`ifndef SYNTHESIS
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && row_end && last_row |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap at end of frame");
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && row_end |=> col_q == '0 && held_left_q == '0)
    else $error("column state not cleared at end of row");
`endif

endmodule

`default_nettype wire

### design/lsh_fifo.sv
// Short queue of neighborhood entries between the front end and the back end.
`default_nettype none

module lsh_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsh_pkg::lsh_entry_t data_i,
  output logic                full_o,
  output logic                valid_o,
  output lsh_pkg::lsh_entry_t data_o,
  input  logic                pop_i
);
  import lsh_pkg::*;

  lsh_entry_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]     count_q;
  logic                    do_push, do_pop;

  assign full_o  = count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + (FIFO_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (FIFO_PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/lsh_back.sv
// Back end: sharpen arithmetic, clamp, border zeroing and the output register.
`default_nettype none

module lsh_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  lsh_pkg::lsh_entry_t         q_entry_i,
  output logic                        q_pop_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [lsh_pkg::PIX_W-1:0]   m_tdata_o,
  output logic                        m_tlast_o
);
  import lsh_pkg::*;

  logic               out_valid_q, second_q;
  logic [PIX_W-1:0]   out_data_q;
  logic               out_last_q;
  logic               load;
  logic [10:0]        c5;
  logic [9:0]         nsum;
  logic signed [11:0] diff;
  logic [PIX_W-1:0]   value;

  always_comb begin
    c5   = {1'b0, q_entry_i.center, 2'b00} + {3'b000, q_entry_i.center};
    nsum = {2'b00, q_entry_i.left} + {2'b00, q_entry_i.right}
         + {2'b00, q_entry_i.up} + {2'b00, q_entry_i.down};
    diff = $signed({1'b0, c5}) - $signed({2'b00, nsum});
    if (q_entry_i.border || diff < 12'sd0) begin
      value = '0;
    end else if (diff > 12'sd255) begin
      value = '1;
    end else begin
      value = diff[PIX_W-1:0];
    end
  end

  assign load    = q_valid_i && (!out_valid_q || m_tready_i);
  // last-row entries stay at the head for their second, zero border result
  assign q_pop_o = load && (second_q || !q_entry_i.last_row);

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= second_q ? '0 : value;
      out_last_q <= second_q && q_entry_i.row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        second_q    <= !second_q && q_entry_i.last_row;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_second_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> q_valid_i && q_entry_i.last_row)
    else $error("second result pending without a last-row entry at the head");
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> m_tdata_o == '0)
    else $error("frame end flagged on a non-border pixel");
`endif

endmodule

`default_nettype wire

### tb/sv/laplacian_sharpen_3x3_unit_tb.sv
// Self-checking stream testbench for the 3x3 cross-kernel sharpen unit.
`timescale 1ns / 1ps

module laplacian_sharpen_3x3_unit_tb;
  import lsh_pkg::*;

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int MAX_H         = MAX_HEIGHT_DEF;
  localparam int RANDOM_PIXELS = 740;
  localparam int LONG_HOLD     = 200;   // receiver hold-off, in cycles
  localparam int QUIET_LIMIT   = 3000;  // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES = 6;     // queue and output register drain, plus margin

  // One sharpened pixel as the output side should present it.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_last;
  } sharp_px_t;

  // Clock, reset and every block input start at known values.
  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic [PIX_W-1:0]      s_tdata   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  cfg_ready;

  laplacian_sharpen_3x3_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),    // [7:0] pixel_in
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),    // [7:0] pixel_out
    .m_tlast_o   (m_tlast),    // frame_last
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  // Pixels waiting to be offered, and sharpened pixels waiting to come out.
  logic [PIX_W-1:0] pixel_q[$];
  sharp_px_t        sharpened_q[$];

  // Shadow of the block: line stores, raster position, left-column hold, registers.
  logic [PIX_W-1:0]     above_line[MAX_W];
  logic [PIX_W-1:0]     two_above_line[MAX_W];
  int unsigned          col_cnt;
  int unsigned          row_cnt;
  logic [PIX_W-1:0]     held_left;
  logic [FRAME_W_W-1:0] width_reg;
  logic [FRAME_H_W-1:0] height_reg;

  // Idling knobs, percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // Long receiver hold-off: requested by the stimulus, counted by the ready process.
  bit          hold_go   = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned errors       = 0;
  int unsigned pixels_in    = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done  = 0;
  int unsigned reg_writes   = 0;
  int unsigned clamp_hi     = 0;
  int unsigned clamp_lo     = 0;
  int unsigned random_px    = 0;
  int unsigned quiet_cycles = 0;
  sharp_px_t   oldest;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Out-of-range register values behave as the nearest legal size.
  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_H) return MAX_H;
    return height_reg;
  endfunction

  // Advance the shadow by one accepted pixel and queue what it produces: the
  // row-above pixel (zero on borders), plus a zero border pixel on the last row.
  function automatic void sharpen_predict(input logic [PIX_W-1:0] px);
    int unsigned      w, h, c, r;
    logic             row_end, last_row;
    logic [PIX_W-1:0] old_above;
    int               acc;
    w         = eff_width();
    h         = eff_height();
    c         = col_cnt % MAX_W;
    r         = row_cnt;
    row_end   = (c >= w - 1);
    last_row  = (r >= h - 1);
    old_above = above_line[c];
    if (r >= 1) begin
      acc = 0;
      if (!(r == 1 || c == 0 || row_end)) begin
        acc = 5 * int'(old_above) - int'(held_left) - int'(above_line[(c + 1) % MAX_W])
            - int'(two_above_line[c]) - int'(px);
        if (acc < 0) begin
          acc = 0;
          clamp_lo++;
        end else if (acc > 255) begin
          acc = 255;
          clamp_hi++;
        end
      end
      sharpened_q.push_back('{pixel: PIX_W'(acc), frame_last: 1'b0});
      if (last_row) sharpened_q.push_back('{pixel: '0, frame_last: row_end});
    end
    two_above_line[c] = old_above;
    above_line[c]     = px;
    held_left         = old_above;
    if (row_end) begin
      col_cnt   = 0;
      held_left = '0;
      if (last_row) begin
        row_cnt = 0;
        frames_done++;
      end else begin
        row_cnt = r + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("MISMATCH %s on result %0d: expected %0d, got %0d", what, results_seen, exp_v,
             got_v);
    errors++;
  endtask

  // Driver: predict on each pixel transfer, then offer the next pixel or idle.
  // tvalid is only dropped between transfers, never while a pixel is offered.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        sharpen_predict(s_tdata);
        pixels_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: each output transfer against the oldest sharpened pixel in line.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (sharpened_q.size() == 0) begin
        report_mismatch("unexpected pixel_out", -1, m_tdata);
      end else begin
        oldest = sharpened_q.pop_front();
        if (m_tdata !== oldest.pixel) report_mismatch("pixel_out", oldest.pixel, m_tdata);
        if (m_tlast !== oldest.frame_last)
          report_mismatch("frame_last", oldest.frame_last, m_tlast);
      end
      results_seen++;
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding", quiet_cycles,
                 sharpened_q.size());
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic set_idling(input int unsigned mode);
    @(negedge clk_i);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 45; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 45; end
      default: begin send_idle_pct = 8; stall_pct = 8; end
    endcase
  endtask

  // Idle: nothing left to send or receive, then let the pipeline drain, since
  // row-0 pixels leave nothing behind to wait on.
  task automatic wait_idle();
    do @(negedge clk_i); while (pixel_q.size() != 0 || s_tvalid || sharpened_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) width_reg = val[FRAME_W_W-1:0];
    else height_reg = val;
    reg_writes++;
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] v);
    @(negedge clk_i);
    pixel_q.push_back(v);
  endtask

  // Random pixels, biased toward the rails so both clamps fire often.
  task automatic queue_random(input int unsigned n);
    logic [PIX_W-1:0] v;
    @(negedge clk_i);
    repeat (n) begin
      case ($urandom_range(7))
        0:       v = '0;
        1:       v = '1;
        default: v = PIX_W'($urandom_range(255));
      endcase
      pixel_q.push_back(v);
      random_px++;
    end
  endtask

  // Only valid when idle: the shadow position is then the block's position.
  // A column at or past a narrowed width ends the row on the next pixel.
  task automatic queue_rest_of_frame();
    int unsigned w, h, n;
    w = eff_width();
    h = eff_height();
    n = (col_cnt >= w - 1) ? 1 : w - col_cnt;
    if (row_cnt < h - 1) n += (h - 1 - row_cnt) * w;
    queue_random(n);
  endtask

  initial begin
    int unsigned frame_idx, w, h, n;
    logic [CFG_DATA_W-1:0] wv, hv;
    bit changed;
    for (int i = 0; i < MAX_W; i++) begin
      above_line[i]     = '0;
      two_above_line[i] = '0;
    end
    col_cnt    = 0;
    row_cnt    = 0;
    held_left  = '0;
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset size: one full 640-pixel row, then two pixels of row 1 must already
    // produce output. Then narrow to 4 wide mid-row and cut the frame at 3 rows.
    queue_random(642);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd4);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    queue_rest_of_frame();
    wait_idle();

    // Smallest frame, width written with a bit above the register (dropped).
    // Bright center on black clamps high; dark center on white clamps low.
    write_reg(CFG_FRAME_WIDTH, 13'h1003);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) queue_pixel((i == 4) ? 8'd255 : 8'd0);
    for (int i = 0; i < 9; i++) queue_pixel((i == 4) ? 8'd0 : 8'd255);
    wait_idle();

    // Ramp frame, 4 x 3: in-range results, no clamping.
    write_reg(CFG_FRAME_WIDTH, 13'd4);
    for (int i = 0; i < 12; i++) queue_pixel(PIX_W'(10 * (i + 1)));
    wait_idle();

    // Receiver holds off for a long stretch while pixels keep coming: the
    // block must fill up and back-pressure its input without losing data.
    write_reg(CFG_FRAME_HEIGHT, 13'd6);
    write_reg(CFG_FRAME_WIDTH, 13'd12);
    @(negedge clk_i);
    hold_go = 1'b1;
    queue_random(72);
    wait_idle();

    // Over-range writes (clamped to the maximum size): a long stretch of row 0
    // runs without a row end, then shrink mid-row to 6 x 3 to finish quickly.
    write_reg(CFG_FRAME_WIDTH, 13'd4095);
    write_reg(CFG_FRAME_HEIGHT, 13'd8191);
    queue_random(40);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd6);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    queue_rest_of_frame();
    wait_idle();

    // Zero in both registers acts as the 3 x 3 minimum.
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    queue_rest_of_frame();

    // Random frames: mostly small, some wider; occasional under-range and
    // masked-bit writes; some frames resized mid-way (width only narrower,
    // so no line store entry is read before it was written).
    random_px = 0;
    frame_idx = 0;
    while (random_px < RANDOM_PIXELS) begin
      set_idling((frame_idx / 3) % 4);
      wait_idle();
      wv = ($urandom_range(4) == 0) ? CFG_DATA_W'($urandom_range(64, 11))
                                    : CFG_DATA_W'($urandom_range(10, 3));
      if ($urandom_range(9) == 0) wv = CFG_DATA_W'($urandom_range(2, 0));
      if ($urandom_range(5) == 0) wv[CFG_DATA_W-1] = 1'b1;
      hv = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2, 0))
                                    : CFG_DATA_W'($urandom_range(8, 3));
      if ($urandom_range(1) == 0) begin
        write_reg(CFG_FRAME_WIDTH, wv);
        write_reg(CFG_FRAME_HEIGHT, hv);
      end else begin
        write_reg(CFG_FRAME_HEIGHT, hv);
        write_reg(CFG_FRAME_WIDTH, wv);
      end
      if ($urandom_range(3) == 0) begin
        w = eff_width();
        h = eff_height();
        n = $urandom_range(w * h - 1, 1);
        queue_random(n);
        wait_idle();
        changed = 1'b0;
        if ($urandom_range(1) == 0) begin
          write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(eff_width(), 0)));
          changed = 1'b1;
        end
        if (!changed || $urandom_range(1) == 0)
          write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(8, 0)));
      end
      queue_rest_of_frame();
      frame_idx++;
    end

    wait_idle();
    $display("Run: %0d pixels in, %0d results checked, %0d frames, %0d register writes",
             pixels_in, results_seen, frames_done, reg_writes);
    $display("Run: %0d results clamped high, %0d clamped low, %0d random frames",
             clamp_hi, clamp_lo, frame_idx);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
